// ===== rtl/chi_pkg.sv =====
// ----------------------------------------------------------------------------
// chi_pkg
// Shared types and constants for the chained hash table: the command and
// status groups between controller and datapath, and the result codes.
// ----------------------------------------------------------------------------
package chi_pkg;

    // Fixed widths of the item and result fields.
    localparam int ITEM_W  = 16;
    localparam int POS_W   = 4;
    // Value bits folded into the bucket remainder per hashing cycle.
    localparam int HASH_DIGIT = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_LOOKUP,
        ST_INSERT,
        ST_SCAN,
        ST_RESULT
    } chi_state_t;

    typedef enum logic [1:0] {
        RES_INSERTED,
        RES_DROPPED,
        RES_FOUND,
        RES_MISSING
    } chi_res_t;

    typedef struct packed {
        logic     load;
        logic     hash_step;
        logic     lookup;
        logic     write;
        logic     scan_step;
        logic     set_result;
        chi_res_t res_code;
        logic     out_load;
    } chi_cmd_t;

    typedef struct packed {
        logic is_search;
        logic hash_last;
        logic full;
        logic hit;
        logic exhausted;
        logic out_busy;
    } chi_status_t;

endpackage

// ===== rtl/chi_ctrl.sv =====
// ----------------------------------------------------------------------------
// chi_ctrl
// Sequencer for one operation at a time: hash, bucket lookup, the insert
// write or drop, or the bucket walk, then hand-off to the output register.
// ----------------------------------------------------------------------------
module chi_ctrl
    import chi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  chi_status_t stat,
    output chi_cmd_t    cmd
);

    chi_state_t state_reg;
    chi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.hash_last)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = stat.is_search ? ST_SCAN : ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                if (stat.hit || stat.exhausted)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_INSERT:
            begin
                cmd.set_result = 1'b1;
                if (stat.full)
                begin
                    cmd.res_code = RES_DROPPED;
                end
                else
                begin
                    cmd.write    = 1'b1;
                    cmd.res_code = RES_INSERTED;
                end
            end
            ST_SCAN:
            begin
                priority if (stat.hit)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_code   = RES_FOUND;
                end
                else if (stat.exhausted)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_code   = RES_MISSING;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESULT:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/chi_dpath.sv =====
// ----------------------------------------------------------------------------
// chi_dpath
// Datapath: digit-serial modulo hash, per-bucket fill counts, entry memory
// with a registered read port, bucket walk with compare, output register.
// ----------------------------------------------------------------------------
module chi_dpath
    import chi_pkg::*;
#(
    parameter int BUCKET_COUNT = 7,
    parameter int BUCKET_DEPTH = 8,
    parameter int VALUE_BITS   = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                action,
    input  logic [ITEM_W-1:0]   item_value,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [POS_W-1:0]    match_position,
    output logic                status,
    input  chi_cmd_t            cmd,
    output chi_status_t         stat
);

    localparam int IN_BITS    = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
    localparam int HASH_CYC   = (IN_BITS + HASH_DIGIT - 1) / HASH_DIGIT;
    localparam int HASH_BITS  = HASH_CYC * HASH_DIGIT;
    localparam int HC_W       = $clog2(HASH_CYC) + 1;
    localparam int REM_W      = $clog2(BUCKET_COUNT);
    localparam int TOTAL      = BUCKET_COUNT * BUCKET_DEPTH;
    localparam int MEM_AW     = $clog2(TOTAL);
    localparam int PTR_W      = $clog2(TOTAL + 1);
    localparam int FILL_W     = $clog2(BUCKET_DEPTH + 1);

    logic                  act_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [HASH_BITS-1:0]  hsh_reg;
    logic [HC_W-1:0]       hcnt_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     bucket_fill_reg [BUCKET_COUNT];
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic [PTR_W-1:0]      top_next;
    logic [FILL_W-1:0]     left_reg;
    logic [FILL_W-1:0]     pos_reg;
    logic                  pend_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] mem [TOTAL];
    logic [FILL_W-1:0]     res_pos_reg;
    logic                  res_stat_reg;
    logic                  out_valid_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_stat_reg;
    logic [FILL_W+POS_W-1:0] pos_wide;

    // Remainder update for one digit: a compare and subtract per bit keeps
    // the partial remainder below the bucket count.
    always_comb
    begin
        logic [REM_W:0] t;
        logic [REM_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < HASH_DIGIT; i++)
        begin
            t = {r, hsh_reg[HASH_BITS-1-i]};
            if (t >= (REM_W+1)'(BUCKET_COUNT))
            begin
                t = t - (REM_W+1)'(BUCKET_COUNT);
            end
            r = t[REM_W-1:0];
        end
        rem_next = r;
    end

    assign top_next = PTR_W'(rem_reg) * PTR_W'(BUCKET_DEPTH)
                    + PTR_W'(bucket_fill_reg[rem_reg]);
    assign ptr_next = ptr_reg - PTR_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            val_reg <= VALUE_BITS'(item_value[IN_BITS-1:0]);
            hsh_reg <= HASH_BITS'(item_value[IN_BITS-1:0]);
            rem_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            hsh_reg <= hsh_reg << HASH_DIGIT;
            rem_reg <= rem_next;
        end
        if (cmd.lookup)
        begin
            fill_reg <= bucket_fill_reg[rem_reg];
            ptr_reg  <= top_next;
            left_reg <= bucket_fill_reg[rem_reg];
            pos_reg  <= '0;
        end
        else if (cmd.scan_step && (left_reg != '0))
        begin
            ptr_reg  <= ptr_next;
            left_reg <= left_reg - FILL_W'(1);
            pos_reg  <= pos_reg + FILL_W'(1);
        end
        if (cmd.set_result)
        begin
            unique case (cmd.res_code)
                RES_INSERTED:
                begin
                    res_pos_reg  <= '0;
                    res_stat_reg <= 1'b0;
                end
                RES_DROPPED:
                begin
                    res_pos_reg  <= '0;
                    res_stat_reg <= 1'b1;
                end
                RES_FOUND:
                begin
                    res_pos_reg  <= pos_reg;
                    res_stat_reg <= 1'b0;
                end
                RES_MISSING:
                begin
                    res_pos_reg  <= '0;
                    res_stat_reg <= 1'b0;
                end
                default:
                begin
                    res_pos_reg  <= '0;
                    res_stat_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_pos_reg  <= pos_wide[POS_W-1:0];
            out_stat_reg <= res_stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            hcnt_reg <= HC_W'(HASH_CYC - 1);
        end
        else if (cmd.hash_step && (hcnt_reg != '0))
        begin
            hcnt_reg <= hcnt_reg - HC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKET_COUNT; i++)
            begin
                bucket_fill_reg[i] <= '0;
            end
        end
        else if (cmd.write)
        begin
            bucket_fill_reg[rem_reg] <= fill_reg + FILL_W'(1);
        end
    end

    // A read issued in one cycle is compared in the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pend_reg <= (left_reg != '0);
        end
        else
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[ptr_reg[MEM_AW-1:0]] <= val_reg;
        end
        if (cmd.scan_step && (left_reg != '0))
        begin
            rd_data_reg <= mem[ptr_next[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pos_wide = {{POS_W{1'b0}}, res_pos_reg};

    assign stat.is_search = act_reg;
    assign stat.hash_last = (hcnt_reg == '0);
    assign stat.full      = (fill_reg >= FILL_W'(BUCKET_DEPTH));
    assign stat.hit       = pend_reg && (rd_data_reg == val_reg);
    assign stat.exhausted = !pend_reg && (left_reg == '0);
    assign stat.out_busy  = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign match_position = out_pos_reg;
    assign status         = out_stat_reg;

endmodule

// ===== rtl/chained_hash_insert_search.sv =====
// ----------------------------------------------------------------------------
// chained_hash_insert_search
// Hash table with buckets chosen by value modulo BUCKET_COUNT, each bucket a
// bounded stack. Inserts push onto the bucket; searches walk newest first.
//
//   Channel   Signals                          Direction
//   input     in_valid, in_stall, action,      in (in_stall out)
//             item_value
//   output    out_valid, out_stall,            out (out_stall in)
//             match_position, status
//
// One operation is in flight at a time. An insert passes through hashing
// at four value bits per cycle, lookup, the write (skipped when the bucket
// is full) and result, and the next beat can be taken once the result is
// shown. A search replaces the write by the bucket walk, which reads entries
// newest first and compares each read while issuing the next one; when
// nothing matches, the miss is reported after the last compare.
// Reset clears the bucket fill counts; entries need no clearing.
// A new beat is taken while a finished result waits in the output register;
// an output stall holds the next result, and the input, until it clears.
// ----------------------------------------------------------------------------
module chained_hash_insert_search
    import chi_pkg::*;
#(
    parameter int BUCKET_COUNT = 7,
    parameter int BUCKET_DEPTH = 8,
    parameter int VALUE_BITS   = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [ITEM_W-1:0] item_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  match_position,
    output logic              status
);

    chi_cmd_t    cmd;
    chi_status_t stat;

    chi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    chi_dpath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .item_value     (item_value),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .match_position (match_position),
        .status         (status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
